// File: sv/hbq_pkg.sv
package hbq_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_CHK,
      ST_DN_CHILD,
      ST_DN_MOVE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } ram_ctl_type;

endpackage

// File: sv/hbq_ram.sv
module hbq_ram (
   input  logic                             clock,
   input  hbq_pkg::ram_ctl_type             ctl,
   output logic        [hbq_pkg::DATA_W-1:0] rd_data_a,
   output logic        [hbq_pkg::DATA_W-1:0] rd_data_b
);

   logic [hbq_pkg::DATA_W-1:0] mem [hbq_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_a <= mem[ctl.rd_addr_a];
      rd_data_b <= mem[ctl.rd_addr_b];
   end

endmodule

// File: sv/hbq_cmp.sv
module hbq_cmp (
   input  logic [hbq_pkg::DATA_W-1:0] a_in,
   input  logic [hbq_pkg::DATA_W-1:0] b_in,
   output logic                       gt
);

   // signed greater-than on two's complement patterns
   assign gt = $signed(a_in) > $signed(b_in);

endmodule

// File: sv/binary_max_heap_queue_top.sv
// Max priority queue of signed 32-bit values held as a binary heap in a
// 64-entry single-write, dual-read memory with registered read data. Each
// transaction inserts a value, removes the maximum or only queries, and
// always returns one result transaction with the removed value, a failure
// flag, the new maximum, the new count and an empty flag. The work is done by
// a small sequencer that walks the heap one level at a time through the
// memory and one shared signed comparator: insert reads the parent, then
// compares and moves, for each level climbed, and settles at the root or
// below a larger parent; remove fetches the last entry, then for each level
// descended reads both children, picks the larger, compares and moves, and
// settles at a leaf or where no child is larger. With 64 entries an insert
// climbs up to six levels and a remove descends up to five. A finished
// result is offered once the output register is free; otherwise the
// sequencer holds in its done state until it is. Each transaction is
// accepted in idle, so the next one is taken only once the sequencer is back.
// req_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next transaction can be accepted before the
// previous result is taken. The root is mirrored in a register so the
// maximum is available without a memory read. No clearing pass is needed
// after reset: only entries below the count are ever used.
module binary_max_heap_queue_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic        [1:0]                 req_func,
   input  logic signed [31:0]                req_value,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_taken_value,
   output logic                              rsp_op_failed,
   output logic signed [31:0]                rsp_top_value,
   output logic        [6:0]                 rsp_entry_count,
   output logic                              rsp_empty_flag
);

   localparam int ADDR_W = hbq_pkg::ADDR_W;
   localparam int CNT_W  = hbq_pkg::CNT_W;
   localparam int DATA_W = hbq_pkg::DATA_W;

   // sequencer state
   hbq_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0]  best_ff, best_in;
   logic [DATA_W-1:0]  val_ff, val_in;       // value being sifted (the hole's content)
   logic [DATA_W-1:0]  bval_ff, bval_in;     // larger child's value
   logic [DATA_W-1:0]  root_ff, root_in;     // mirror of heap entry 0
   logic [DATA_W-1:0]  taken_ff, taken_in;
   logic               failed_ff, failed_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_taken_ff, rsp_taken_in;
   logic               rsp_failed_ff, rsp_failed_in;
   logic [DATA_W-1:0]  rsp_top_ff, rsp_top_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // memory and comparator hookup
   hbq_pkg::ram_ctl_type ram_ctl;
   logic [DATA_W-1:0]    rd_data_a, rd_data_b;
   logic [DATA_W-1:0]    cmp_a, cmp_b;
   logic                 cmp_gt;

   // heap index arithmetic, one bit wider than the count
   logic [CNT_W:0]       left_idx, right_idx, n_ext;
   logic [ADDR_W-1:0]    parent_idx;

   assign left_idx   = {{(CNT_W - ADDR_W){1'b0}}, pos_ff, 1'b1};
   assign right_idx  = left_idx + {{CNT_W{1'b0}}, 1'b1};
   assign n_ext      = {1'b0, count_ff};
   assign parent_idx = (pos_ff - {{(ADDR_W-1){1'b0}}, 1'b1}) >> 1;

   hbq_ram u_ram (
      .clock     (clock),
      .ctl       (ram_ctl),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   hbq_cmp u_cmp (
      .a_in (cmp_a),
      .b_in (cmp_b),
      .gt   (cmp_gt)
   );

   // the single comparator is steered by state
   always_comb begin
      case (state_ff)
         hbq_pkg::ST_UP_CMP: begin
            cmp_a = val_ff;
            cmp_b = rd_data_a;
         end
         hbq_pkg::ST_DN_CHILD: begin
            cmp_a = rd_data_b;
            cmp_b = rd_data_a;
         end
         default: begin
            cmp_a = bval_ff;
            cmp_b = val_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      val_in       = val_ff;
      bval_in      = bval_ff;
      taken_in     = taken_ff;
      failed_in    = failed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_taken_in = rsp_taken_ff;
      rsp_failed_in = rsp_failed_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_count_in = rsp_count_ff;
      ram_ctl.wr_en     = 1'b0;
      ram_ctl.wr_addr   = pos_ff;
      ram_ctl.wr_data   = val_ff;
      ram_ctl.rd_addr_a = left_idx[ADDR_W-1:0];
      ram_ctl.rd_addr_b = right_idx[ADDR_W-1:0];
      req_ready    = 1'b0;

      // result taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         hbq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               taken_in  = hbq_pkg::MOST_NEG;
               failed_in = 1'b0;
               state_in  = hbq_pkg::ST_DONE;
               if (req_func == hbq_pkg::FUNC_INSERT) begin
                  if (count_ff == CNT_W'(hbq_pkg::CAPACITY)) begin
                     failed_in = 1'b1;
                  end else begin
                     val_in   = req_value;
                     pos_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                     state_in = hbq_pkg::ST_UP_CHK;
                  end
               end else if (req_func == hbq_pkg::FUNC_REMOVE) begin
                  if (count_ff == '0) begin
                     failed_in = 1'b1;
                  end else begin
                     taken_in = root_ff;
                     count_in = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
                     pos_in   = '0;
                     // fetch the last entry; nothing to sift if it was the only one
                     ram_ctl.rd_addr_a = count_in[ADDR_W-1:0];
                     if (count_in != '0) begin
                        state_in = hbq_pkg::ST_DN_LOAD;
                     end
                  end
               end
            end
         end

         // sift up: hole at pos, climb while parent strictly smaller
         hbq_pkg::ST_UP_CHK: begin
            ram_ctl.rd_addr_a = parent_idx;
            if (pos_ff == '0) begin
               ram_ctl.wr_en = 1'b1;
               state_in      = hbq_pkg::ST_DONE;
            end else begin
               state_in = hbq_pkg::ST_UP_CMP;
            end
         end

         hbq_pkg::ST_UP_CMP: begin
            ram_ctl.wr_en = 1'b1;
            if (cmp_gt) begin
               ram_ctl.wr_data = rd_data_a;
               pos_in          = parent_idx;
               state_in        = hbq_pkg::ST_UP_CHK;
            end else begin
               state_in = hbq_pkg::ST_DONE;
            end
         end

         hbq_pkg::ST_DN_LOAD: begin
            val_in   = rd_data_a;
            state_in = hbq_pkg::ST_DN_CHK;
         end

         // sift down: read both children of the hole
         hbq_pkg::ST_DN_CHK: begin
            if (left_idx >= n_ext) begin
               ram_ctl.wr_en = 1'b1;
               state_in      = hbq_pkg::ST_DONE;
            end else begin
               state_in = hbq_pkg::ST_DN_CHILD;
            end
         end

         // larger child, left wins a tie
         hbq_pkg::ST_DN_CHILD: begin
            if ((right_idx < n_ext) && cmp_gt) begin
               best_in = right_idx[ADDR_W-1:0];
               bval_in = rd_data_b;
            end else begin
               best_in = left_idx[ADDR_W-1:0];
               bval_in = rd_data_a;
            end
            state_in = hbq_pkg::ST_DN_MOVE;
         end

         hbq_pkg::ST_DN_MOVE: begin
            ram_ctl.wr_en = 1'b1;
            if (cmp_gt) begin
               ram_ctl.wr_data = bval_ff;
               pos_in          = best_ff;
               state_in        = hbq_pkg::ST_DN_CHK;
            end else begin
               state_in = hbq_pkg::ST_DONE;
            end
         end

         // hand the result over once the output register is free
         hbq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_taken_in  = taken_ff;
               rsp_failed_in = failed_ff;
               rsp_top_in    = (count_ff == '0) ? hbq_pkg::MOST_NEG : root_ff;
               rsp_count_in  = count_ff;
               state_in      = hbq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = hbq_pkg::ST_IDLE;
         end
      endcase
   end

   // root mirror follows every write to entry 0
   assign root_in = (ram_ctl.wr_en && ram_ctl.wr_addr == '0) ? ram_ctl.wr_data : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      best_ff       <= best_in;
      val_ff        <= val_in;
      bval_ff       <= bval_in;
      root_ff       <= root_in;
      taken_ff      <= taken_in;
      failed_ff     <= failed_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_failed_ff <= rsp_failed_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taken_value = rsp_taken_ff;
   assign rsp_op_failed   = rsp_failed_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_empty_flag  = (rsp_count_ff == '0);

endmodule
